/* hdl/annexb_pkg.sv */
package annexb_pkg;

    localparam int POS_BITS = 24;
    localparam int OUT_BITS = 24;
    localparam int QDEPTH   = 4;
    localparam int QAW      = $clog2(QDEPTH);

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    typedef logic [POS_BITS-1:0] pos_t;

    localparam pos_t                POS_MAX = {POS_BITS{1'b1}};
    localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } in_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] unit_offset;
        logic [OUT_BITS-1:0] unit_length;
        logic                final_unit;
        logic                too_long;
    } out_t;

    // One classified byte: up to two units to report, previous one first
    typedef struct packed {
        logic has_prev;
        logic has_last;
        out_t prev;
        out_t last;
    } cmd_t;

    function automatic logic pos_over(pos_t v);
        logic [63:0] w;
        w = 64'(v);
        return w > 64'(OUT_MAX);
    endfunction

    function automatic logic [OUT_BITS-1:0] pos_fit(pos_t v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
    endfunction

    function automatic out_t make_result(pos_t offset, pos_t length, logic fin, logic ovf);
        out_t r;
        r.unit_offset = pos_fit(offset);
        r.unit_length = pos_fit(length);
        r.final_unit  = fin;
        r.too_long    = ovf | pos_over(offset) | pos_over(length);
        return r;
    endfunction

endpackage

/* hdl/annexb_scan.sv */
module annexb_scan
    import annexb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    input  logic q_ready,
    output logic push,
    output cmd_t cmd
);

    pos_t       pos_reg, pos_next;
    logic [1:0] zrun_reg, zrun_next;
    logic       open_reg, open_next;
    pos_t       start_reg, start_next;
    logic       ovf_reg, ovf_next;

    logic accept;
    logic at_max;
    pos_t next_pos;
    logic ovf_now;
    logic is_sc;
    pos_t k;
    pos_t begin_pos;
    pos_t prev_len;
    pos_t last_start;
    logic last_open;
    pos_t last_len;

    assign in_stall = ~q_ready;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        at_max     = (pos_reg == POS_MAX);
        next_pos   = at_max ? pos_reg : pos_reg + pos_t'(1);
        ovf_now    = ovf_reg | at_max;
        is_sc      = (in_data.data_byte == BYTE_ONE) && (zrun_reg >= 2'd2);
        k          = pos_t'(zrun_reg);
        begin_pos  = (pos_reg >= k) ? pos_reg - k : '0;
        prev_len   = (begin_pos >= start_reg) ? begin_pos - start_reg : '0;
        last_start = is_sc ? next_pos : start_reg;
        last_open  = open_reg | is_sc;
        last_len   = (next_pos >= last_start) ? next_pos - last_start : '0;

        cmd.has_prev = is_sc & open_reg;
        cmd.has_last = in_data.end_of_packet & last_open;
        cmd.prev     = make_result(start_reg, prev_len, 1'b0, ovf_now);
        cmd.last     = make_result(last_start, last_len, 1'b1, ovf_now);
        push         = accept & (cmd.has_prev | cmd.has_last);

        pos_next   = pos_reg;
        zrun_next  = zrun_reg;
        open_next  = open_reg;
        start_next = start_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (in_data.end_of_packet)
            begin
                pos_next   = '0;
                zrun_next  = '0;
                open_next  = 1'b0;
                start_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                pos_next = next_pos;
                ovf_next = ovf_now;
                if (in_data.data_byte == BYTE_ZERO)
                begin
                    if (zrun_reg != 2'd3)
                        zrun_next = zrun_reg + 2'd1;
                end
                else if (is_sc)
                begin
                    open_next  = 1'b1;
                    start_next = next_pos;
                    zrun_next  = '0;
                end
                else
                begin
                    zrun_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            zrun_reg  <= '0;
            open_reg  <= 1'b0;
            start_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            zrun_reg  <= zrun_next;
            open_reg  <= open_next;
            start_reg <= start_next;
            ovf_reg   <= ovf_next;
        end
    end

    // packet end must leave the scanner clean for the next packet
    a_eop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.end_of_packet |=> pos_reg == '0 && !open_reg && zrun_reg == '0)
        else $error("scanner state not cleared after packet end");

endmodule

/* hdl/annexb_fifo.sv */
module annexb_fifo
    import annexb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic ready,
    input  logic pop,
    output logic avail,
    output cmd_t pop_data
);

    cmd_t           mem [QDEPTH];
    logic [QAW-1:0] wr_reg, wr_next;
    logic [QAW-1:0] rd_reg, rd_next;
    logic [QAW:0]   count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign ready    = (count_reg != (QAW+1)'(QDEPTH));
    assign avail    = (count_reg != '0);
    assign pop_data = mem[rd_reg];
    assign do_push  = push & ready;
    assign do_pop   = pop & avail;

    always_comb
    begin
        wr_next    = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = do_pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("queue written while full");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_reg == rd_reg)
        else $error("queue pointers disagree with empty count");

endmodule

/* hdl/annexb_emit.sv */
module annexb_emit
    import annexb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic avail,
    input  cmd_t cmd,
    output logic pop,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    out_t out_reg, out_next;
    logic valid_reg, valid_next;
    out_t pend_reg, pend_next;
    logic pend_valid_reg, pend_valid_next;
    logic free;

    assign out_valid = valid_reg;
    assign out_data  = out_reg;
    assign free      = ~valid_reg | ~out_stall;
    assign pop       = free & ~pend_valid_reg & avail;

    always_comb
    begin
        out_next        = out_reg;
        valid_next      = valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (free)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                valid_next      = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (avail)
            begin
                valid_next = 1'b1;
                if (cmd.has_prev)
                begin
                    out_next        = cmd.prev;
                    pend_next       = cmd.last;
                    pend_valid_next = cmd.has_last;
                end
                else
                begin
                    out_next = cmd.last;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // the held second unit of a packet is always its final one
    a_pend_final: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> valid_reg && pend_reg.final_unit && !out_reg.final_unit)
        else $error("pending result out of order");

endmodule

/* hdl/annexb_nal_unit_splitter.sv */
// Annex B start code scanner: takes one packet byte per cycle unless the queue is full,
// and reports, for each NAL unit, the payload offset and length; the unit that ends with
// the packet carries final_unit. A scanner registers the byte position and zero-run
// history and classifies each byte combinationally; a 4-entry queue decouples it from an
// output register that presents one result per cycle unless the receiver stalls.
// Throughput is one byte per cycle while the queue has room; a packet-end byte that both
// closes a unit and starts one yields two results, which the queue absorbs.
module annexb_nal_unit_splitter
    import annexb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    logic q_ready;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic avail;
    cmd_t pop_cmd;

    annexb_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_ready  (q_ready),
        .push     (push),
        .cmd      (push_cmd)
    );

    annexb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .ready     (q_ready),
        .pop       (pop),
        .avail     (avail),
        .pop_data  (pop_cmd)
    );

    annexb_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .cmd       (pop_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import annexb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TOTAL_ITEMS  = 1700;
    localparam int CALM_ITEMS   = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    typedef logic [7:0] byte_q_t[$];

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;

    annexb_nal_unit_splitter uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Scanner copy: position, zero history, open unit
    pos_t       scan_pos;
    logic [1:0] scan_zeros;
    logic       scan_open;
    pos_t       scan_start;
    logic       scan_ovf;

    out_t expected_units[$];
    out_t want_unit;
    int   mismatches;
    int   sent_items;
    int   cycles;
    int   stall_left;
    bit   idle_en;

    task automatic clear_scan_state();
        scan_pos   = '0;
        scan_zeros = '0;
        scan_open  = 1'b0;
        scan_start = '0;
        scan_ovf   = 1'b0;
    endtask

    task automatic queue_unit(pos_t offset, pos_t length, logic fin);
        out_t       u;
        logic [63:0] ow;
        logic [63:0] lw;
        ow = 64'(offset);
        lw = 64'(length);
        u.too_long = scan_ovf;
        if (ow > 64'(OUT_MAX))
        begin
            u.unit_offset = OUT_MAX;
            u.too_long    = 1'b1;
        end
        else
            u.unit_offset = ow[OUT_BITS-1:0];
        if (lw > 64'(OUT_MAX))
        begin
            u.unit_length = OUT_MAX;
            u.too_long    = 1'b1;
        end
        else
            u.unit_length = lw[OUT_BITS-1:0];
        u.final_unit = fin;
        expected_units.push_back(u);
    endtask

    // Advance the scanner by one byte and queue the units it closes
    task automatic scan_byte(in_t item);
        logic [POS_BITS:0] wide;
        pos_t              p;
        pos_t              nxt;
        pos_t              code_first;
        pos_t              len;
        p    = scan_pos;
        wide = {1'b0, p} + 1'b1;
        if (wide > {1'b0, POS_MAX})
        begin
            nxt      = POS_MAX;
            scan_ovf = 1'b1;
        end
        else
            nxt = wide[POS_BITS-1:0];
        scan_pos = nxt;

        if (item.data_byte == BYTE_ZERO)
        begin
            if (scan_zeros != 2'd3)
                scan_zeros = scan_zeros + 2'd1;
        end
        else if (item.data_byte == BYTE_ONE && scan_zeros >= 2'd2)
        begin
            code_first = (p >= pos_t'(scan_zeros)) ? p - pos_t'(scan_zeros) : '0;
            if (scan_open)
            begin
                len = (code_first >= scan_start) ? code_first - scan_start : '0;
                queue_unit(scan_start, len, 1'b0);
            end
            scan_open  = 1'b1;
            scan_start = nxt;
            scan_zeros = '0;
        end
        else
            scan_zeros = '0;

        if (item.end_of_packet)
        begin
            if (scan_open)
            begin
                len = (nxt >= scan_start) ? nxt - scan_start : '0;
                queue_unit(scan_start, len, 1'b1);
            end
            clear_scan_state();
        end
    endtask

    task automatic send_byte(logic [7:0] b, logic eop);
        in_t item;
        int  gap;
        item.data_byte     = b;
        item.end_of_packet = eop;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        scan_byte(item);
        sent_items++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_packet(byte_q_t pkt);
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    function automatic logic [7:0] noisy_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return BYTE_ZERO;
        else if (sel == 4)
            return BYTE_ONE;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] payload_byte();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel < 2)
            return BYTE_ZERO;
        else if (sel == 2)
            return BYTE_ONE;
        return 8'($urandom);
    endfunction

    function automatic byte_q_t build_packet();
        byte_q_t pkt;
        int      kind;
        int      cut;
        kind = $urandom_range(0, 9);
        if (kind == 7)
        begin
            // noise: no structure at all
            repeat ($urandom_range(1, 12)) pkt.push_back(noisy_byte());
            return pkt;
        end
        repeat ($urandom_range(0, 2)) pkt.push_back(payload_byte());
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 1) == 1)
                pkt.push_back(BYTE_ZERO);
            pkt.push_back(BYTE_ZERO);
            pkt.push_back(BYTE_ZERO);
            pkt.push_back(BYTE_ONE);
            repeat ($urandom_range(0, 8)) pkt.push_back(payload_byte());
        end
        if (kind == 9)
        begin
            // close the packet on a start code
            pkt.push_back(BYTE_ZERO);
            pkt.push_back(BYTE_ZERO);
            pkt.push_back(BYTE_ONE);
        end
        else if (kind == 8)
        begin
            cut = $urandom_range(0, pkt.size() - 1);
            pkt = pkt[0:cut];
        end
        return pkt;
    endfunction

    task automatic test_directed();
        byte_q_t pkt;
        // two units, the second behind a 4-byte code
        pkt = {8'h00, 8'h00, 8'h01, 8'h11, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
        send_packet(pkt);
        // empty unit, then a start code on the final byte
        pkt = {8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
        send_packet(pkt);
        // leading junk and a long zero run before the code
        pkt = {8'h7E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80};
        send_packet(pkt);
        // single zero before 01 is no start code
        pkt = {8'h00, 8'h01};
        send_packet(pkt);
    endtask

    task automatic test_random_traffic(int count);
        int stop_at;
        stop_at = sent_items + count;
        while (sent_items < stop_at)
            send_packet(build_packet());
    endtask

    task automatic test_no_idle_traffic();
        idle_en = 1'b0;
        test_random_traffic(CALM_ITEMS);
    endtask

    // Receiver backpressure in random bursts
    always @(negedge clk)
    begin
        if (!idle_en)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 4);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_units.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: offset=%0d length=%0d final=%0b too_long=%0b",
                             out_data.unit_offset, out_data.unit_length,
                             out_data.final_unit, out_data.too_long);
            end
            else
            begin
                want_unit = expected_units.pop_front();
                if (out_data.unit_offset !== want_unit.unit_offset ||
                    out_data.unit_length !== want_unit.unit_length ||
                    out_data.final_unit  !== want_unit.final_unit  ||
                    out_data.too_long    !== want_unit.too_long)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: expected %0d/%0d/%0b/%0b, actual %0d/%0d/%0b/%0b",
                                 want_unit.unit_offset, want_unit.unit_length,
                                 want_unit.final_unit, want_unit.too_long,
                                 out_data.unit_offset, out_data.unit_length,
                                 out_data.final_unit, out_data.too_long);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        idle_en    = 1'b1;
        stall_left = 0;
        mismatches = 0;
        sent_items = 0;
        cycles     = 0;
        clear_scan_state();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traffic(TOTAL_ITEMS - CALM_ITEMS);
        test_no_idle_traffic();

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_units.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/annexb_pkg.sv
hdl/annexb_scan.sv
hdl/annexb_fifo.sv
hdl/annexb_emit.sv
hdl/annexb_nal_unit_splitter.sv
dv/tb_top.sv
